### sv/bfp_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared constants, command codes and a helper function for the five-probe
// Bloom filter core.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int MAX_FILTER_BYTES = 1024;

  localparam int CMD_W      = 3;
  localparam int WORD_W     = 32;
  localparam int NUM_PROBES = 5;
  localparam int PROBE_W    = $clog2(NUM_PROBES);
  localparam int CFG_W      = 11;
  localparam int BYTE_IDX_W = 10;
  localparam int BYTE_W     = 8;
  localparam int BIT_SEL_W  = 3;
  localparam int BIT_IDX_W  = CFG_W + BIT_SEL_W;
  localparam int FILL_W     = 14;
  localparam int POP_W      = 4;

  localparam int DIGIT_BITS = 4;
  localparam int MOD_STEPS  = WORD_W / DIGIT_BITS;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  localparam logic [CFG_W-1:0]  CFG_RESET = 11'd1024;
  localparam logic [WORD_W-1:0] COLL_MAX  = '1;

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MERGE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd4;

  function automatic logic [POP_W-1:0] popcount8(input logic [BYTE_W-1:0] b);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + POP_W'(b[i]);
    end
    return n;
  endfunction

endpackage

### sv/bloom_filter_five_probe.sv
// ----------------------------------------------------------------------------
// Bloom filter core, five probes per transaction
// Add and check run each of the five probes through the shared
//   4-bit-per-cycle remainder unit and a read-modify-write on the single
//   store port; merge does one read-modify-write of an in-range byte, clear
//   zeroes every byte, count reads the used bytes, others go to the result.
// Throughput: one transaction at a time; the next can be accepted once
//   the result is registered.
// Reset: synchronous; a clearing pass zeroes all MAX_FILTER_BYTES bytes of the
//   store while in_ready stays low. Configuration writes are taken always.
// ----------------------------------------------------------------------------
module bloom_filter_five_probe #(
  parameter int MAX_FILTER_BYTES = bfp_pkg::MAX_FILTER_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bfp_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bfp_pkg::CMD_W-1:0]       in_command,
  input  logic [bfp_pkg::WORD_W-1:0]      in_hash_word0,
  input  logic [bfp_pkg::WORD_W-1:0]      in_hash_word1,
  input  logic [bfp_pkg::WORD_W-1:0]      in_hash_word2,
  input  logic [bfp_pkg::WORD_W-1:0]      in_hash_word3,
  input  logic [bfp_pkg::WORD_W-1:0]      in_hash_word4,
  input  logic [bfp_pkg::BYTE_IDX_W-1:0]  in_byte_index,
  input  logic [bfp_pkg::BYTE_W-1:0]      in_byte_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_present,
  output logic [bfp_pkg::WORD_W-1:0]      out_collision_total,
  output logic [bfp_pkg::FILL_W-1:0]      out_filled_bits
);

  localparam int AW       = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
  localparam int CW       = (AW > bfp_pkg::CFG_W) ? AW : bfp_pkg::CFG_W;
  localparam int USED_CAP = (MAX_FILTER_BYTES < 2047) ? MAX_FILTER_BYTES : 2047;
  localparam logic [AW-1:0]             ADDR_LAST = AW'(MAX_FILTER_BYTES - 1);
  localparam logic [AW-1:0]             ADDR_ONE  = AW'(1);
  localparam logic [bfp_pkg::CFG_W-1:0] CFG_CAP   = bfp_pkg::CFG_W'(USED_CAP);
  localparam logic [bfp_pkg::CFG_W-1:0] CFG_ONE   = bfp_pkg::CFG_W'(1);
  localparam logic [bfp_pkg::PROBE_W-1:0] PROBE_LAST =
    bfp_pkg::PROBE_W'(bfp_pkg::NUM_PROBES - 1);
  localparam logic [bfp_pkg::PROBE_W-1:0] PROBE_ONE = bfp_pkg::PROBE_W'(1);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MOD   = 9'b000000100,
    S_RD    = 9'b000001000,
    S_RMW   = 9'b000010000,
    S_CLEAR = 9'b000100000,
    S_CNT   = 9'b001000000,
    S_CNTL  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                           state_r;
  state_t                           state_nxt;
  logic [bfp_pkg::CFG_W-1:0]        cfg_r;
  logic [AW-1:0]                    addr_r;
  logic [bfp_pkg::PROBE_W-1:0]      probe_r;
  logic [bfp_pkg::CMD_W-1:0]        cmd_r;
  logic [bfp_pkg::WORD_W-1:0]       hash_r [bfp_pkg::NUM_PROBES];
  logic [bfp_pkg::BYTE_W-1:0]       bval_r;
  logic [bfp_pkg::BIT_SEL_W-1:0]    bitsel_r;
  logic                             present_r;
  logic [bfp_pkg::FILL_W-1:0]       acc_r;
  logic [bfp_pkg::WORD_W-1:0]       coll_r;
  logic                             out_valid_r;
  logic                             out_present_r;
  logic [bfp_pkg::WORD_W-1:0]       out_coll_r;
  logic [bfp_pkg::FILL_W-1:0]       out_fill_r;

  logic [bfp_pkg::CFG_W-1:0]        used_w;
  logic [bfp_pkg::BIT_IDX_W-1:0]    nbits_w;
  logic                             accept;
  logic                             probe_cmd;
  logic                             out_load;
  logic                             cnt_last;
  logic                             merge_ok;
  logic                             bit_hit;
  logic [bfp_pkg::PROBE_W-1:0]      probe_nxt;

  logic                             mod_start;
  logic [bfp_pkg::WORD_W-1:0]       mod_dividend;
  logic                             mod_done;
  logic [bfp_pkg::BIT_IDX_W-1:0]    mod_rem;

  logic                             mem_we;
  logic                             mem_re;
  logic [bfp_pkg::BYTE_W-1:0]       mem_wdata;
  logic [bfp_pkg::BYTE_W-1:0]       mem_rdata;

  always_comb begin
    if (cfg_r == '0) begin
      used_w = CFG_ONE;
    end else if (cfg_r > CFG_CAP) begin
      used_w = CFG_CAP;
    end else begin
      used_w = cfg_r;
    end
  end

  assign nbits_w   = {used_w, 3'b000};
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign probe_cmd = (in_command == bfp_pkg::CMD_ADD) || (in_command == bfp_pkg::CMD_CHECK);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign cnt_last  = (CW'(addr_r) == CW'(used_w - CFG_ONE));
  assign merge_ok  = ({1'b0, in_byte_index} < used_w);
  assign bit_hit   = mem_rdata[bitsel_r];
  assign probe_nxt = probe_r + PROBE_ONE;

  assign mod_start = (accept && probe_cmd) ||
                     ((state_r == S_RMW) && (cmd_r != bfp_pkg::CMD_MERGE) &&
                      (probe_r != PROBE_LAST));
  assign mod_dividend = (state_r == S_IDLE) ? in_hash_word0 : hash_r[probe_nxt];

  bfp_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (nbits_w),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign mem_re = (state_r == S_RD) || (state_r == S_CNT);
  assign mem_we = (state_r == S_INIT) || (state_r == S_CLEAR) ||
                  ((state_r == S_RMW) && (cmd_r != bfp_pkg::CMD_CHECK));

  always_comb begin
    if ((state_r == S_INIT) || (state_r == S_CLEAR)) begin
      mem_wdata = '0;
    end else if (cmd_r == bfp_pkg::CMD_MERGE) begin
      mem_wdata = mem_rdata | bval_r;
    end else begin
      mem_wdata = mem_rdata | (bfp_pkg::BYTE_W'(1) << bitsel_r);
    end
  end

  bfp_store #(
    .DEPTH (MAX_FILTER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (addr_r),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (addr_r == ADDR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_command) inside
            bfp_pkg::CMD_ADD,
            bfp_pkg::CMD_CHECK: state_nxt = S_MOD;
            bfp_pkg::CMD_CLEAR: state_nxt = S_CLEAR;
            bfp_pkg::CMD_MERGE: state_nxt = merge_ok ? S_RD : S_DONE;
            bfp_pkg::CMD_COUNT: state_nxt = S_CNT;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_RMW;
      end
      S_RMW: begin
        if ((cmd_r == bfp_pkg::CMD_MERGE) || (probe_r == PROBE_LAST)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_CLEAR: begin
        if (addr_r == ADDR_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_CNT: begin
        if (cnt_last) begin
          state_nxt = S_CNTL;
        end
      end
      S_CNTL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cfg_r       <= bfp_pkg::CFG_RESET;
      addr_r      <= '0;
      probe_r     <= '0;
      cmd_r       <= bfp_pkg::CMD_ADD;
      present_r   <= 1'b0;
      acc_r       <= '0;
      coll_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r) inside
        S_INIT, S_CLEAR: begin
          addr_r <= addr_r + ADDR_ONE;
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= in_command;
            probe_r   <= '0;
            present_r <= 1'b1;
            acc_r     <= '0;
            addr_r    <= (in_command == bfp_pkg::CMD_MERGE) ? AW'(in_byte_index) : '0;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            addr_r <= AW'(mod_rem[bfp_pkg::BIT_IDX_W-1:bfp_pkg::BIT_SEL_W]);
          end
        end
        S_RMW: begin
          if (cmd_r == bfp_pkg::CMD_ADD) begin
            if (bit_hit && (coll_r != bfp_pkg::COLL_MAX)) begin
              coll_r <= coll_r + 32'd1;
            end
          end else if (cmd_r == bfp_pkg::CMD_CHECK) begin
            if (!bit_hit) begin
              present_r <= 1'b0;
            end
          end
          probe_r <= probe_nxt;
        end
        S_CNT: begin
          if (addr_r != '0) begin
            acc_r <= acc_r + bfp_pkg::FILL_W'(bfp_pkg::popcount8(mem_rdata));
          end
          addr_r <= addr_r + ADDR_ONE;
        end
        S_CNTL: begin
          acc_r <= acc_r + bfp_pkg::FILL_W'(bfp_pkg::popcount8(mem_rdata));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hash_r[0] <= in_hash_word0;
      hash_r[1] <= in_hash_word1;
      hash_r[2] <= in_hash_word2;
      hash_r[3] <= in_hash_word3;
      hash_r[4] <= in_hash_word4;
      bval_r    <= in_byte_value;
    end
    if ((state_r == S_MOD) && mod_done) begin
      bitsel_r <= mod_rem[bfp_pkg::BIT_SEL_W-1:0];
    end
    if (out_load) begin
      out_present_r <= (cmd_r == bfp_pkg::CMD_CHECK) && present_r;
      out_coll_r    <= coll_r;
      out_fill_r    <= (cmd_r == bfp_pkg::CMD_COUNT) ? acc_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_present         = out_present_r;
  assign out_collision_total = out_coll_r;
  assign out_filled_bits     = out_fill_r;

  a_mod_done_in_mod : assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("Remainder unit finished outside the probe wait state.");

  a_coll_monotone : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (coll_r >= $past(coll_r)))
    else $error("Collision count decreased.");

  a_accept_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("Block stayed ready after accepting a transaction.");

  a_load_presents : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && in_ready))
    else $error("Result load did not present a result and return to idle.");

endmodule

### sv/bfp_mod_unit.sv
// ----------------------------------------------------------------------------
// Bloom filter remainder unit
// Iterative restoring remainder of a 32-bit word by the filter bit length,
// several dividend bits per cycle.
// ----------------------------------------------------------------------------
module bfp_mod_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bfp_pkg::WORD_W-1:0]     dividend,
  input  logic [bfp_pkg::BIT_IDX_W-1:0]  divisor,
  output logic                           done,
  output logic [bfp_pkg::BIT_IDX_W-1:0]  rem
);

  localparam logic [bfp_pkg::MOD_CNT_W-1:0] MOD_CNT_ONE  = bfp_pkg::MOD_CNT_W'(1);
  localparam logic [bfp_pkg::MOD_CNT_W-1:0] MOD_CNT_LAST =
    bfp_pkg::MOD_CNT_W'(bfp_pkg::MOD_STEPS - 1);

  logic                           busy_r;
  logic                           done_r;
  logic [bfp_pkg::MOD_CNT_W-1:0]  cnt_r;
  logic [bfp_pkg::WORD_W-1:0]     q_r;
  logic [bfp_pkg::WORD_W-1:0]     q_nxt;
  logic [bfp_pkg::BIT_IDX_W-1:0]  rem_r;
  logic [bfp_pkg::BIT_IDX_W-1:0]  rem_nxt;

  always_comb begin
    logic [bfp_pkg::BIT_IDX_W:0] wide;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int i = 0; i < bfp_pkg::DIGIT_BITS; i++) begin
      wide  = {rem_nxt, q_nxt[bfp_pkg::WORD_W-1]};
      q_nxt = {q_nxt[bfp_pkg::WORD_W-2:0], 1'b0};
      if (wide >= {1'b0, divisor}) begin
        wide = wide - {1'b0, divisor};
      end
      rem_nxt = wide[bfp_pkg::BIT_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + MOD_CNT_ONE;
      if (cnt_r == MOD_CNT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### sv/bfp_store.sv
// ----------------------------------------------------------------------------
// Bloom filter bit store
// Single-port byte memory with a registered read.
// ----------------------------------------------------------------------------
module bfp_store #(
  parameter int DEPTH = bfp_pkg::MAX_FILTER_BYTES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic                          re,
  input  logic [AW-1:0]                 addr,
  input  logic [bfp_pkg::BYTE_W-1:0]    wdata,
  output logic [bfp_pkg::BYTE_W-1:0]    rdata
);

  logic [bfp_pkg::BYTE_W-1:0] mem_r [DEPTH];
  logic [bfp_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the five-probe Bloom filter core
// Drives add, check, clear, merge, count and reserved command transactions
// under random sender bursts and receiver stalls, predicts every result with
// a behavioral copy of the filter store and collision counter, and compares
// the results field by field in order. Filter lengths from 0 to 2047 are used.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [bfp_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [bfp_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  typedef logic [bfp_pkg::NUM_PROBES-1:0][bfp_pkg::WORD_W-1:0] digest_t;

  typedef struct packed {
    logic [bfp_pkg::CMD_W-1:0]      command;
    digest_t                        words;
    logic [bfp_pkg::BYTE_IDX_W-1:0] byte_index;
    logic [bfp_pkg::BYTE_W-1:0]     byte_value;
  } filter_txn_t;

  typedef struct packed {
    logic                       present;
    logic [bfp_pkg::WORD_W-1:0] collision_total;
    logic [bfp_pkg::FILL_W-1:0] filled_bits;
  } filter_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [bfp_pkg::CFG_W-1:0]      cfg_wr_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [bfp_pkg::CMD_W-1:0]      in_command;
  logic [bfp_pkg::WORD_W-1:0]     in_hash_word0;
  logic [bfp_pkg::WORD_W-1:0]     in_hash_word1;
  logic [bfp_pkg::WORD_W-1:0]     in_hash_word2;
  logic [bfp_pkg::WORD_W-1:0]     in_hash_word3;
  logic [bfp_pkg::WORD_W-1:0]     in_hash_word4;
  logic [bfp_pkg::BYTE_IDX_W-1:0] in_byte_index;
  logic [bfp_pkg::BYTE_W-1:0]     in_byte_value;
  logic                           out_valid;
  logic                           out_ready;
  logic                           out_present;
  logic [bfp_pkg::WORD_W-1:0]     out_collision_total;
  logic [bfp_pkg::FILL_W-1:0]     out_filled_bits;

  logic [bfp_pkg::BYTE_W-1:0] model_store [bfp_pkg::MAX_FILTER_BYTES];
  logic [bfp_pkg::WORD_W-1:0] model_collisions;
  logic [bfp_pkg::CFG_W-1:0]  model_length;

  filter_result_t pending_results [$];
  digest_t        key_pool [$];

  int error_count      = 0;
  int reports_shown    = 0;
  int results_checked  = 0;
  int lengths_used     = 0;
  int burst_left       = 0;
  int holdoff_requests = 0;
  int holdoff_length   = 0;
  int cmd_count [8];

  bloom_filter_five_probe DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_hash_word0       (in_hash_word0),
    .in_hash_word1       (in_hash_word1),
    .in_hash_word2       (in_hash_word2),
    .in_hash_word3       (in_hash_word3),
    .in_hash_word4       (in_hash_word4),
    .in_byte_index       (in_byte_index),
    .in_byte_value       (in_byte_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_present         (out_present),
    .out_collision_total (out_collision_total),
    .out_filled_bits     (out_filled_bits)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned active_bytes();
    if (model_length == '0) begin
      return 1;
    end
    if (model_length > bfp_pkg::CFG_W'(bfp_pkg::MAX_FILTER_BYTES)) begin
      return bfp_pkg::MAX_FILTER_BYTES;
    end
    return int'(model_length);
  endfunction

  function automatic int unsigned bit_slot(logic [bfp_pkg::WORD_W-1:0] word);
    int unsigned bits;
    bits = active_bytes() * 8;
    return word % bits;
  endfunction

  function automatic filter_result_t predict_filter(filter_txn_t t);
    filter_result_t r;
    int unsigned    slot;
    int unsigned    total;
    r = '0;
    case (t.command)
      bfp_pkg::CMD_ADD: begin
        for (int k = 0; k < bfp_pkg::NUM_PROBES; k++) begin
          slot = bit_slot(t.words[k]);
          if (model_store[slot / 8][slot % 8] && model_collisions != bfp_pkg::COLL_MAX) begin
            model_collisions = model_collisions + 1'b1;
          end
          model_store[slot / 8][slot % 8] = 1'b1;
        end
      end
      bfp_pkg::CMD_CHECK: begin
        r.present = 1'b1;
        for (int k = 0; k < bfp_pkg::NUM_PROBES; k++) begin
          slot = bit_slot(t.words[k]);
          if (!model_store[slot / 8][slot % 8]) begin
            r.present = 1'b0;
          end
        end
      end
      bfp_pkg::CMD_CLEAR: begin
        for (int i = 0; i < bfp_pkg::MAX_FILTER_BYTES; i++) begin
          model_store[i] = '0;
        end
      end
      bfp_pkg::CMD_MERGE: begin
        if (int'(t.byte_index) < active_bytes()) begin
          model_store[t.byte_index] = model_store[t.byte_index] | t.byte_value;
        end
      end
      bfp_pkg::CMD_COUNT: begin
        total = 0;
        for (int i = 0; i < active_bytes(); i++) begin
          for (int j = 0; j < bfp_pkg::BYTE_W; j++) begin
            total = total + model_store[i][j];
          end
        end
        r.filled_bits = total[bfp_pkg::FILL_W-1:0];
      end
      default: begin
      end
    endcase
    r.collision_total = model_collisions;
    return r;
  endfunction

  function automatic digest_t random_digest();
    digest_t d;
    for (int k = 0; k < bfp_pkg::NUM_PROBES; k++) begin
      case ($urandom_range(0, 15))
        0: d[k] = '0;
        1: d[k] = '1;
        default: d[k] = $urandom;
      endcase
    end
    return d;
  endfunction

  task automatic send_item(input filter_txn_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= t.command;
    in_hash_word0 <= t.words[0];
    in_hash_word1 <= t.words[1];
    in_hash_word2 <= t.words[2];
    in_hash_word3 <= t.words[3];
    in_hash_word4 <= t.words[4];
    in_byte_index <= t.byte_index;
    in_byte_value <= t.byte_value;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_filter(t));
    cmd_count[t.command]++;
  endtask

  task automatic send_command(input logic [bfp_pkg::CMD_W-1:0] cmd, input digest_t words,
                              input logic [bfp_pkg::BYTE_IDX_W-1:0] idx,
                              input logic [bfp_pkg::BYTE_W-1:0] val);
    filter_txn_t t;
    t.command    = cmd;
    t.words      = words;
    t.byte_index = idx;
    t.byte_value = val;
    send_item(t);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_filter_length(input logic [bfp_pkg::CFG_W-1:0] value);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_length = value;
    lengths_used++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (reports_shown < 10) begin
          reports_shown++;
          $display("Unexpected result: present=%0d collision_total=%0d filled_bits=%0d",
                   out_present, out_collision_total, out_filled_bits);
        end
      end else begin
        filter_result_t e;
        e = pending_results.pop_front();
        if (out_present !== e.present || out_collision_total !== e.collision_total ||
            out_filled_bits !== e.filled_bits) begin
          error_count++;
          if (reports_shown < 10) begin
            reports_shown++;
            $display("Mismatch at %0t: expected present=%0d collision_total=%0d filled_bits=%0d",
                     $realtime, e.present, e.collision_total, e.filled_bits);
            $display("                 actual   present=%0d collision_total=%0d filled_bits=%0d",
                     out_present, out_collision_total, out_filled_bits);
          end
        end
      end
    end
  end

  // The receiver rotates a stall pattern that is replaced now and then, and
  // serves requests for one long hold-off.
  initial begin
    int          hold_left;
    int          served;
    int          pattern_age;
    logic [15:0] pattern;
    hold_left   = 0;
    served      = 0;
    pattern_age = 0;
    pattern     = '1;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (served != holdoff_requests) begin
        served = holdoff_requests;
        hold_left = holdoff_length;
      end
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(40, 160);
        pattern = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        if (pattern == '0) begin
          pattern = 16'h0001;
        end
      end
      pattern_age--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= pattern[0];
      end
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  task automatic test_empty_filter();
    send_command(bfp_pkg::CMD_COUNT, '0, '0, '0);
    send_command(bfp_pkg::CMD_CHECK, '0, '0, '0);
  endtask

  task automatic test_probe_extremes();
    send_command(bfp_pkg::CMD_ADD, '0, '0, '0);
    send_command(bfp_pkg::CMD_ADD, '1, '1, '1);
    send_command(bfp_pkg::CMD_CHECK, '0, '0, '0);
    send_command(bfp_pkg::CMD_CHECK, '1, '1, '1);
    send_command(bfp_pkg::CMD_CHECK,
                 {32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF}, '0, '0);
    send_command(bfp_pkg::CMD_COUNT, '0, '0, '0);
  endtask

  task automatic test_merge_bytes();
    send_command(bfp_pkg::CMD_MERGE, '0, 10'd0, 8'hFF);
    send_command(bfp_pkg::CMD_MERGE, '0, 10'd1023, 8'h81);
    send_command(bfp_pkg::CMD_COUNT, '0, '0, '0);
  endtask

  task automatic test_reserved_commands();
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
      send_command(bfp_pkg::CMD_W'(c), random_digest(), 10'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_clear_store();
    send_command(bfp_pkg::CMD_CLEAR, '0, '0, '0);
    send_command(bfp_pkg::CMD_COUNT, '0, '0, '0);
    send_command(bfp_pkg::CMD_CHECK, '1, '0, '0);
  endtask

  task automatic test_length_limits();
    write_filter_length(11'd0);
    send_command(bfp_pkg::CMD_ADD, {32'hFFFFFFFF, 32'd7, 32'd2, 32'd9, 32'd1}, '0, '0);
    send_command(bfp_pkg::CMD_MERGE, '0, 10'd1, 8'hFF);
    send_command(bfp_pkg::CMD_MERGE, '0, 10'd0, 8'h10);
    send_command(bfp_pkg::CMD_COUNT, '0, '0, '0);
    write_filter_length(11'd2047);
    send_command(bfp_pkg::CMD_MERGE, '0, 10'd1023, 8'h3C);
    send_command(bfp_pkg::CMD_COUNT, '0, '0, '0);
    write_filter_length(11'd1024);
  endtask

  task automatic test_output_stall();
    wait_for_drain();
    holdoff_length = 400;
    holdoff_requests++;
    burst_left = 10;
    for (int i = 0; i < 8; i++) begin
      send_command(i % 2 ? bfp_pkg::CMD_CHECK : bfp_pkg::CMD_ADD, random_digest(),
                   10'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned lengths [15];
    filter_txn_t t;
    digest_t     d;
    int          pick;
    lengths = '{1, 2, 3, 7, 8, 33, 64, 100, 255, 511, 1024, 1025, 2047, 0, 0};
    lengths[14] = $urandom_range(1, 2047);
    for (int p = 0; p < 15; p++) begin
      write_filter_length(bfp_pkg::CFG_W'(lengths[p]));
      for (int n = 0; n < 110; n++) begin
        pick = $urandom_range(0, 99);
        d = random_digest();
        if (key_pool.size() != 0 && ((pick >= 38 && pick < 50) || (pick >= 50 && pick < 72))) begin
          d = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        t.words      = d;
        t.byte_index = 10'($urandom);
        t.byte_value = 8'($urandom);
        if (pick < 50) begin
          t.command = bfp_pkg::CMD_ADD;
          if (pick < 38) begin
            key_pool.push_back(d);
            if (key_pool.size() > 24) begin
              void'(key_pool.pop_front());
            end
          end
        end else if (pick < 84) begin
          t.command = bfp_pkg::CMD_CHECK;
        end else if (pick < 90) begin
          t.command = bfp_pkg::CMD_MERGE;
          if ($urandom_range(0, 1)) begin
            t.byte_index = 10'($urandom_range(0, active_bytes() - 1));
          end
        end else if (pick < 94) begin
          t.command = bfp_pkg::CMD_COUNT;
        end else if (pick < 96) begin
          t.command = bfp_pkg::CMD_CLEAR;
        end else begin
          t.command = bfp_pkg::CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        end
        send_item(t);
      end
    end
  endtask

  initial begin
    int reserved_total;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_command    = '0;
    in_hash_word0 = '0;
    in_hash_word1 = '0;
    in_hash_word2 = '0;
    in_hash_word3 = '0;
    in_hash_word4 = '0;
    in_byte_index = '0;
    in_byte_value = '0;
    for (int i = 0; i < bfp_pkg::MAX_FILTER_BYTES; i++) begin
      model_store[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      cmd_count[i] = 0;
    end
    model_collisions = '0;
    model_length     = bfp_pkg::CFG_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_filter();
    test_probe_extremes();
    test_merge_bytes();
    test_reserved_commands();
    test_clear_store();
    test_length_limits();
    test_output_stall();
    test_random_traffic();

    wait_for_drain();
    repeat (1100) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived.", pending_results.size());
    end
    reserved_total = 0;
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
      reserved_total += cmd_count[c];
    end
    $display("Sent %0d add, %0d check, %0d clear, %0d merge, %0d count",
             cmd_count[bfp_pkg::CMD_ADD], cmd_count[bfp_pkg::CMD_CHECK],
             cmd_count[bfp_pkg::CMD_CLEAR], cmd_count[bfp_pkg::CMD_MERGE],
             cmd_count[bfp_pkg::CMD_COUNT]);
    $display("and %0d reserved transactions; checked %0d results over %0d length writes.",
             reserved_total, results_checked, lengths_used);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #120_000_000;
    $display("Run stopped by the time limit with %0d results outstanding.",
             pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
